// ===== sv/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg: shared types and constants of the clock frame replacement core
// Holds the item structs, operation, status, action and page type codes,
// and the table geometry.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int FRAME_SLOTS = 64;
  localparam int SLOT_W      = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int CNT_W       = $clog2(2 * FRAME_SLOTS + 1);
  localparam int FRAME_W     = 6;

  localparam logic [31:0] USER_LOW  = 32'h0804_8000;
  localparam logic [31:0] USER_HIGH = 32'hc000_0000;

  // Operation codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TOUCH  = 2'd2;
  localparam logic [1:0] OP_EVICT  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_VICTIM = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  // Action codes.
  localparam logic [1:0] ACT_DISCARD   = 2'd0;
  localparam logic [1:0] ACT_SWAP_OUT  = 2'd1;
  localparam logic [1:0] ACT_WRITEBACK = 2'd2;

  // Page types.
  localparam logic [1:0] PT_BINARY  = 2'd0;
  localparam logic [1:0] PT_FILE    = 2'd1;
  localparam logic [1:0] PT_ANON    = 2'd2;
  localparam logic [1:0] PT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [FRAME_W-1:0] frame;
    logic [31:0]        vaddr;
    logic               mapped;
    logic [1:0]         page_type;
    logic               is_write;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRAME_W-1:0] victim_frame;
    logic [31:0]        victim_vaddr;
    logic [1:0]         action;
  } out_item_t;

  // One entry of the frame memory.
  typedef struct packed {
    logic [31:0] vaddr;
    logic [1:0]  page_type;
  } entry_t;

endpackage

// ===== sv/clock_frame_replacement_core.sv =====
// ----------------------------------------------------------------------------
// clock_frame_replacement_core: second-chance clock over a frame table
// Insert, remove, touch and evict items on a valid/ready channel, one result
// item per input item.
// ----------------------------------------------------------------------------
// Insert, touch and remove answer in the cycle after the item is taken; removing the frame
// under the hand then keeps the core busy in SEEK while the hand walks to the next used slot.
// An evict scans one slot per cycle, at most 2*FRAME_SLOTS slots (128 for 64 slots), then
// reports no victim once the output is free, or reads the victim's entry in READ and moves
// the hand on in SEEK. The core takes one item at a time and accepts the next only in IDLE.
// Reset (synchronous, rst_n low): table empty, hand null, no result pending.
module clock_frame_replacement_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfr_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cfr_pkg::out_item_t out_data
);

  // Sequencer states. FIND steps the hand one slot per cycle, READ waits for
  // the victim's memory entry, SEEK moves the hand off a removed frame.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FIND = 4'b0010,
    S_READ = 4'b0100,
    S_SEEK = 4'b1000
  } state_t;

  localparam int N = cfr_pkg::FRAME_SLOTS;

  state_t                     state_r, state_nxt;
  logic [cfr_pkg::SLOT_W-1:0] hand_r, hand_nxt;
  logic                       hand_set_r, hand_set_nxt;
  logic [cfr_pkg::SLOT_W-1:0] ptr_r, ptr_nxt;
  logic [cfr_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  // Per-slot flags live in flip-flops. The candidate flag is worked out once
  // at insert, so the scan never needs the memory to test a slot.
  logic [N-1:0] used_r, used_nxt;
  logic [N-1:0] acc_r, acc_nxt;
  logic [N-1:0] dirty_r, dirty_nxt;
  logic [N-1:0] cand_r, cand_nxt;

  logic                  out_valid_r, out_valid_nxt;
  cfr_pkg::out_item_t    out_data_r, out_data_nxt;

  // Frame memory: virtual address and page type, one write and one read port.
  cfr_pkg::entry_t       mem [N];
  cfr_pkg::entry_t       mem_q;
  cfr_pkg::entry_t       mem_wdata;
  logic                  mem_we, mem_re;
  logic [cfr_pkg::SLOT_W-1:0] mem_waddr;

  logic                       in_fire, out_free, frame_ok, ins_cand;
  logic [cfr_pkg::SLOT_W-1:0] slot, slot_inc, ptr_inc, hand_inc;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign slot     = cfr_pkg::SLOT_W'(in_data.frame);
  assign frame_ok = 32'(in_data.frame) < 32'(N);

  // Increment with wrap-around at the table size.
  function automatic logic [cfr_pkg::SLOT_W-1:0] wrap_inc(
    input logic [cfr_pkg::SLOT_W-1:0] v
  );
    logic [cfr_pkg::SLOT_W-1:0] r;
    if (32'(v) == 32'(N - 1)) begin
      r = '0;
    end else begin
      r = v + 1'b1;
    end
    return r;
  endfunction

  assign slot_inc = wrap_inc(slot);
  assign ptr_inc  = wrap_inc(ptr_r);
  assign hand_inc = wrap_inc(hand_r);

  // A frame is a candidate if mapped, page aligned and inside the user range.
  assign ins_cand = in_data.mapped && (in_data.vaddr[11:0] == 12'h000)
                    && (in_data.vaddr >= cfr_pkg::USER_LOW)
                    && (in_data.vaddr < cfr_pkg::USER_HIGH);

  assign mem_wdata = '{vaddr: in_data.vaddr, page_type: in_data.page_type};
  assign mem_waddr = slot;

  always_comb begin
    state_nxt     = state_r;
    hand_nxt      = hand_r;
    hand_set_nxt  = hand_set_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    used_nxt      = used_r;
    acc_nxt       = acc_r;
    dirty_nxt     = dirty_r;
    cand_nxt      = cand_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.operation == cfr_pkg::OP_EVICT) begin
            // The hand moves first; a null hand starts from the lowest slot.
            ptr_nxt   = hand_set_r ? hand_inc : '0;
            cnt_nxt   = '0;
            state_nxt = S_FIND;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: cfr_pkg::ST_DONE, default: '0};
            if (frame_ok) begin
              unique case (in_data.operation)
                cfr_pkg::OP_INSERT: begin
                  used_nxt[slot]  = 1'b1;
                  acc_nxt[slot]   = 1'b0;
                  dirty_nxt[slot] = 1'b0;
                  cand_nxt[slot]  = ins_cand;
                  mem_we          = 1'b1;
                end
                cfr_pkg::OP_REMOVE: begin
                  if (used_r[slot]) begin
                    used_nxt[slot]  = 1'b0;
                    acc_nxt[slot]   = 1'b0;
                    dirty_nxt[slot] = 1'b0;
                    if (hand_set_r && hand_r == slot) begin
                      ptr_nxt   = slot_inc;
                      cnt_nxt   = '0;
                      state_nxt = S_SEEK;
                    end
                  end
                end
                default: begin
                  // Touch.
                  if (used_r[slot]) begin
                    acc_nxt[slot] = 1'b1;
                    if (in_data.is_write) begin
                      dirty_nxt[slot] = 1'b1;
                    end
                  end
                end
              endcase
            end
          end
        end
      end

      S_FIND: begin
        if (32'(cnt_r) == 32'(2 * N)) begin
          // Two full passes without a victim.
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: cfr_pkg::ST_NONE, default: '0};
            state_nxt     = S_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          ptr_nxt = ptr_inc;
          if (used_r[ptr_r]) begin
            hand_nxt     = ptr_r;
            hand_set_nxt = 1'b1;
            if (cand_r[ptr_r]) begin
              if (acc_r[ptr_r]) begin
                // Second chance: clear the accessed bit and pass over.
                acc_nxt[ptr_r] = 1'b0;
              end else begin
                mem_re    = 1'b1;
                ptr_nxt   = ptr_r;
                state_nxt = S_READ;
              end
            end
          end
        end
      end

      S_READ: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.victim_frame = cfr_pkg::FRAME_W'(ptr_r);
          out_data_nxt.victim_vaddr = mem_q.vaddr;
          out_data_nxt.status       = cfr_pkg::ST_VICTIM;
          out_data_nxt.action       = cfr_pkg::ACT_DISCARD;
          unique case (mem_q.page_type)
            cfr_pkg::PT_BINARY: begin
              if (dirty_r[ptr_r]) begin
                out_data_nxt.action = cfr_pkg::ACT_SWAP_OUT;
              end
            end
            cfr_pkg::PT_FILE: begin
              if (dirty_r[ptr_r]) begin
                out_data_nxt.action = cfr_pkg::ACT_WRITEBACK;
              end
            end
            cfr_pkg::PT_ANON: begin
              out_data_nxt.action = cfr_pkg::ACT_SWAP_OUT;
            end
            default: begin
              out_data_nxt.status = cfr_pkg::ST_ERROR;
            end
          endcase
          if (mem_q.page_type == cfr_pkg::PT_UNKNOWN) begin
            // The frame stays in the table and the hand stays on it.
            state_nxt = S_IDLE;
          end else begin
            // The victim is removed; the hand sits on it, so move it on.
            used_nxt[ptr_r]  = 1'b0;
            acc_nxt[ptr_r]   = 1'b0;
            dirty_nxt[ptr_r] = 1'b0;
            ptr_nxt          = ptr_inc;
            cnt_nxt          = '0;
            state_nxt        = S_SEEK;
          end
        end
      end

      default: begin
        // S_SEEK: find the next used slot after the removed one.
        if (32'(cnt_r) == 32'(N - 1)) begin
          hand_set_nxt = 1'b0;
          hand_nxt     = '0;
          state_nxt    = S_IDLE;
        end else if (used_r[ptr_r]) begin
          hand_nxt  = ptr_r;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_inc;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hand_r      <= '0;
      hand_set_r  <= 1'b0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      used_r      <= '0;
      acc_r       <= '0;
      dirty_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hand_r      <= hand_nxt;
      hand_set_r  <= hand_set_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      used_r      <= used_nxt;
      acc_r       <= acc_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    cand_r     <= cand_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[ptr_r];
    end
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the clock frame replacement core
// Drives insert, remove, touch and evict items through the valid/ready input
// channel and predicts each result with a cycle-free model of the frame
// table and its second-chance clock hand. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb;

  // The slowest result is an evict that scans two full passes, reads memory
  // and then walks the hand on. The drain waits somewhat longer than that.
  localparam int DRAIN_CYCLES = 250;
  localparam int MAX_REPORTS  = 10;
  localparam int IDLE_PCT     = 37;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  cfr_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  cfr_pkg::out_item_t out_data;

  clock_frame_replacement_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Shadow copy of the frame table and the clock hand.
  logic        tbl_used     [cfr_pkg::FRAME_SLOTS];
  logic [31:0] tbl_vaddr    [cfr_pkg::FRAME_SLOTS];
  logic        tbl_mapped   [cfr_pkg::FRAME_SLOTS];
  logic [1:0]  tbl_type     [cfr_pkg::FRAME_SLOTS];
  logic        tbl_accessed [cfr_pkg::FRAME_SLOTS];
  logic        tbl_dirty    [cfr_pkg::FRAME_SLOTS];
  int          hand_slot;
  logic        hand_live;

  // Results predicted for accepted items, oldest first.
  cfr_pkg::out_item_t pending_outcomes[$];

  // When set, neither side of the bench inserts idle cycles.
  bit steady_flow = 1'b0;

  int fault_count    = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int victims_seen   = 0;
  int none_seen      = 0;
  int type_errs_seen = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Generous upper bound: every item as a worst-case evict with stalls on
  // both sides, taken several times over.
  initial begin
    #4_000_000;
    $display("tb: errors");
    $finish;
  end

  // The receiver drops ready at random, except in the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------

  // Frees a slot. If the hand rests on it, the hand moves on to the next used
  // slot in slot order, or becomes null when the table is left empty.
  function automatic void release_frame(input int s);
    bit found;
    int i;
    found = 1'b0;
    if (hand_live && hand_slot == s) begin
      for (i = 1; i < cfr_pkg::FRAME_SLOTS && !found; i++) begin
        if (tbl_used[(s + i) % cfr_pkg::FRAME_SLOTS]) begin
          hand_slot = (s + i) % cfr_pkg::FRAME_SLOTS;
          found = 1'b1;
        end
      end
      if (!found) begin
        hand_live = 1'b0;
        hand_slot = 0;
      end
    end
    tbl_used[s]     = 1'b0;
    tbl_accessed[s] = 1'b0;
    tbl_dirty[s]    = 1'b0;
  endfunction

  // Only mapped, page-aligned user pages may be chosen.
  function automatic bit is_victim_candidate(input int s);
    logic [31:0] va;
    va = tbl_vaddr[s];
    return tbl_mapped[s] && (va[11:0] == 12'h000) && (va >= cfr_pkg::USER_LOW)
           && (va < cfr_pkg::USER_HIGH);
  endfunction

  // Applies one item to the shadow table and returns the result it causes.
  function automatic cfr_pkg::out_item_t replace_step(input cfr_pkg::in_item_t it);
    cfr_pkg::out_item_t res;
    int start;
    int p;
    int i;
    int f;
    bit stop;
    res  = '0;
    stop = 1'b0;
    f    = int'(it.frame);
    if (it.operation == cfr_pkg::OP_EVICT) begin
      res.status = cfr_pkg::ST_NONE;
      start = hand_live ? (hand_slot + 1) % cfr_pkg::FRAME_SLOTS : 0;
      // The hand advances before each look; at most two full passes.
      for (i = 0; i < 2 * cfr_pkg::FRAME_SLOTS && !stop; i++) begin
        p = (start + i) % cfr_pkg::FRAME_SLOTS;
        if (tbl_used[p]) begin
          hand_slot = p;
          hand_live = 1'b1;
          if (is_victim_candidate(p)) begin
            if (tbl_accessed[p]) begin
              // Second chance: clear the bit and pass over this frame.
              tbl_accessed[p] = 1'b0;
            end else begin
              stop = 1'b1;
              res.status       = cfr_pkg::ST_VICTIM;
              res.victim_frame = cfr_pkg::FRAME_W'(p);
              res.victim_vaddr = tbl_vaddr[p];
              case (tbl_type[p])
                cfr_pkg::PT_BINARY:
                  res.action = tbl_dirty[p] ? cfr_pkg::ACT_SWAP_OUT : cfr_pkg::ACT_DISCARD;
                cfr_pkg::PT_FILE:
                  res.action = tbl_dirty[p] ? cfr_pkg::ACT_WRITEBACK : cfr_pkg::ACT_DISCARD;
                cfr_pkg::PT_ANON:
                  res.action = cfr_pkg::ACT_SWAP_OUT;
                default: begin
                  // Unknown type: reported, the frame stays and so does the hand.
                  res.status = cfr_pkg::ST_ERROR;
                  res.action = cfr_pkg::ACT_DISCARD;
                end
              endcase
              if (res.status == cfr_pkg::ST_VICTIM) release_frame(p);
            end
          end
        end
      end
    end else if (f < cfr_pkg::FRAME_SLOTS) begin
      case (it.operation)
        cfr_pkg::OP_INSERT: begin
          tbl_used[f]     = 1'b1;
          tbl_vaddr[f]    = it.vaddr;
          tbl_mapped[f]   = it.mapped;
          tbl_type[f]     = it.page_type;
          tbl_accessed[f] = 1'b0;
          tbl_dirty[f]    = 1'b0;
        end
        cfr_pkg::OP_REMOVE: begin
          if (tbl_used[f]) release_frame(f);
        end
        default: begin
          if (tbl_used[f]) begin
            tbl_accessed[f] = 1'b1;
            if (it.is_write) tbl_dirty[f] = 1'b1;
          end
        end
      endcase
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every accepted result is matched against the oldest
  // prediction, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cfr_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: result with nothing predicted: status %0d frame %0d vaddr %h action %0d",
                   $time, out_data.status, out_data.victim_frame, out_data.victim_vaddr,
                   out_data.action);
      end else begin
        want = pending_outcomes.pop_front();
        case (want.status)
          cfr_pkg::ST_VICTIM: victims_seen++;
          cfr_pkg::ST_NONE:   none_seen++;
          cfr_pkg::ST_ERROR:  type_errs_seen++;
          default: ;
        endcase
        if (out_data.status !== want.status || out_data.victim_frame !== want.victim_frame ||
            out_data.victim_vaddr !== want.victim_vaddr || out_data.action !== want.action) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("%0t: mismatch: expected status %0d frame %0d vaddr %h action %0d, got status %0d frame %0d vaddr %h action %0d",
                     $time, want.status, want.victim_frame, want.victim_vaddr, want.action,
                     out_data.status, out_data.victim_frame, out_data.victim_vaddr,
                     out_data.action);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Presents one item, holds it until the core takes it, then records the
  // prediction. Idle cycles go in front of the item at random.
  task automatic send_item(input cfr_pkg::in_item_t it);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_outcomes.push_back(replace_step(it));
    items_sent++;
  endtask

  function automatic cfr_pkg::in_item_t make_item(input logic [1:0] op, input int frame,
                                                  input logic [31:0] va, input logic map,
                                                  input logic [1:0] ptype, input logic wr);
    cfr_pkg::in_item_t it;
    it.operation = op;
    it.frame     = cfr_pkg::FRAME_W'(frame);
    it.vaddr     = va;
    it.mapped    = map;
    it.page_type = ptype;
    it.is_write  = wr;
    return it;
  endfunction

  // Mostly well-formed traffic: aligned user pages that are mapped, so evicts
  // find victims. A share of items is pure noise with every field random.
  function automatic cfr_pkg::in_item_t random_item(input int frame_hi, input int noise_pct);
    cfr_pkg::in_item_t it;
    int roll;
    roll = $urandom_range(99);
    if (roll < 35)      it.operation = cfr_pkg::OP_INSERT;
    else if (roll < 62) it.operation = cfr_pkg::OP_TOUCH;
    else if (roll < 72) it.operation = cfr_pkg::OP_REMOVE;
    else                it.operation = cfr_pkg::OP_EVICT;
    it.frame    = cfr_pkg::FRAME_W'($urandom_range(frame_hi));
    it.is_write = 1'($urandom_range(1));
    if ($urandom_range(99) < noise_pct) begin
      it.frame     = cfr_pkg::FRAME_W'($urandom_range(cfr_pkg::FRAME_SLOTS - 1));
      it.vaddr     = $urandom;
      it.mapped    = 1'($urandom_range(1));
      it.page_type = 2'($urandom_range(3));
    end else begin
      it.vaddr     = {20'($urandom_range(20'h08048, 20'hbffff)), 12'h000};
      it.mapped    = ($urandom_range(19) != 0);
      it.page_type = ($urandom_range(19) == 0) ? cfr_pkg::PT_UNKNOWN : 2'($urandom_range(2));
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked items: empty table, free slots, range edges, each page type,
  // the second chance, an unknown type, overwrite, remove under the hand and
  // an evict that finds nothing.
  task automatic test_directed_cases();
    send_item(make_item(cfr_pkg::OP_EVICT,  0, 32'h0, 1'b0, cfr_pkg::PT_BINARY, 1'b0));
    send_item(make_item(cfr_pkg::OP_REMOVE, 7, 32'h0, 1'b0, cfr_pkg::PT_BINARY, 1'b0));
    send_item(make_item(cfr_pkg::OP_TOUCH,  7, 32'h0, 1'b0, cfr_pkg::PT_BINARY, 1'b1));
    send_item(make_item(cfr_pkg::OP_INSERT, 0,  cfr_pkg::USER_LOW, 1'b1,
                        cfr_pkg::PT_BINARY, 1'b0));
    send_item(make_item(cfr_pkg::OP_INSERT, 63, 32'hbfff_f000, 1'b1, cfr_pkg::PT_ANON, 1'b1));
    send_item(make_item(cfr_pkg::OP_INSERT, 5,  32'h1000_0000, 1'b1, cfr_pkg::PT_FILE, 1'b0));
    send_item(make_item(cfr_pkg::OP_INSERT, 10, 32'h2000_0000, 1'b1,
                        cfr_pkg::PT_UNKNOWN, 1'b0));
    send_item(make_item(cfr_pkg::OP_INSERT, 20, 32'h3000_0000, 1'b0,
                        cfr_pkg::PT_BINARY, 1'b0));
    send_item(make_item(cfr_pkg::OP_INSERT, 21, 32'h3000_0800, 1'b1, cfr_pkg::PT_FILE, 1'b0));
    send_item(make_item(cfr_pkg::OP_INSERT, 22, 32'h0804_7000, 1'b1, cfr_pkg::PT_ANON, 1'b0));
    send_item(make_item(cfr_pkg::OP_INSERT, 23, cfr_pkg::USER_HIGH, 1'b1,
                        cfr_pkg::PT_ANON, 1'b0));
    send_item(make_item(cfr_pkg::OP_TOUCH,  0,  32'hffff_ffff, 1'b1,
                        cfr_pkg::PT_UNKNOWN, 1'b0));
    send_item(make_item(cfr_pkg::OP_TOUCH,  5,  32'h0, 1'b0, cfr_pkg::PT_BINARY, 1'b1));
    // Slots 0 and 5 get their second chance, slot 10 reports a type error.
    send_item(make_item(cfr_pkg::OP_EVICT, 0, 32'h0, 1'b0, cfr_pkg::PT_BINARY, 1'b0));
    // Non-candidates are skipped; slot 63 is swapped out, hand wraps to 0.
    send_item(make_item(cfr_pkg::OP_EVICT, 0, 32'h0, 1'b0, cfr_pkg::PT_BINARY, 1'b0));
    // Dirty file page in slot 5 is written back.
    send_item(make_item(cfr_pkg::OP_EVICT, 0, 32'h0, 1'b0, cfr_pkg::PT_BINARY, 1'b0));
    // Overwrite slot 0 with a page just outside the user range.
    send_item(make_item(cfr_pkg::OP_INSERT, 0, 32'hffff_f000, 1'b1, cfr_pkg::PT_BINARY, 1'b0));
    // Slot 10 holds the hand; removing it moves the hand on.
    send_item(make_item(cfr_pkg::OP_REMOVE, 10, 32'h0, 1'b0, cfr_pkg::PT_BINARY, 1'b0));
    // No candidate anywhere: two passes and no victim.
    send_item(make_item(cfr_pkg::OP_EVICT, 0, 32'h0, 1'b0, cfr_pkg::PT_BINARY, 1'b0));
    send_item(make_item(cfr_pkg::OP_INSERT, 40, cfr_pkg::USER_LOW, 1'b1,
                        cfr_pkg::PT_BINARY, 1'b0));
    send_item(make_item(cfr_pkg::OP_TOUCH,  40, 32'h0, 1'b0, cfr_pkg::PT_BINARY, 1'b1));
    // Slot 40 is passed over once, then chosen as a dirty binary page.
    send_item(make_item(cfr_pkg::OP_EVICT, 0, 32'h0, 1'b0, cfr_pkg::PT_BINARY, 1'b0));
    send_item(make_item(cfr_pkg::OP_INSERT, 41, 32'h7fff_f000, 1'b1, cfr_pkg::PT_FILE, 1'b1));
    // Clean file page is simply discarded.
    send_item(make_item(cfr_pkg::OP_EVICT, 0, 32'h0, 1'b0, cfr_pkg::PT_BINARY, 1'b0));
  endtask

  // Random traffic over the whole table with stalls on both sides.
  task automatic test_busy_table();
    repeat (450) send_item(random_item(cfr_pkg::FRAME_SLOTS - 1, 10));
  endtask

  // A long stretch with no idle cycles on either side and a small, dense
  // working set so that evicts hit victims quickly.
  task automatic test_back_to_back();
    steady_flow = 1'b1;
    repeat (250) send_item(random_item(15, 5));
    steady_flow = 1'b0;
  endtask

  // Empties the table so the hand goes null, then refills a little.
  task automatic test_drain_table();
    int s;
    for (s = 0; s < cfr_pkg::FRAME_SLOTS; s++)
      send_item(make_item(cfr_pkg::OP_REMOVE, s, $urandom, 1'($urandom_range(1)),
                          2'($urandom_range(3)), 1'($urandom_range(1))));
    send_item(make_item(cfr_pkg::OP_EVICT, 0, 32'h0, 1'b0, cfr_pkg::PT_BINARY, 1'b0));
    send_item(make_item(cfr_pkg::OP_INSERT, 33, 32'h5000_0000, 1'b1, cfr_pkg::PT_ANON, 1'b0));
    send_item(make_item(cfr_pkg::OP_EVICT, 0, 32'h0, 1'b0, cfr_pkg::PT_BINARY, 1'b0));
  endtask

  // Heavy share of malformed pages: misaligned, unmapped, outside the range.
  task automatic test_sparse_and_noise();
    repeat (250) send_item(random_item(cfr_pkg::FRAME_SLOTS - 1, 40));
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int s;
    for (s = 0; s < cfr_pkg::FRAME_SLOTS; s++) begin
      tbl_used[s]     = 1'b0;
      tbl_vaddr[s]    = '0;
      tbl_mapped[s]   = 1'b0;
      tbl_type[s]     = cfr_pkg::PT_BINARY;
      tbl_accessed[s] = 1'b0;
      tbl_dirty[s]    = 1'b0;
    end
    hand_slot = 0;
    hand_live = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_busy_table();
    test_back_to_back();
    test_drain_table();
    test_sparse_and_noise();
    in_valid <= 1'b0;

    // Let every outstanding result come back, then watch for strays.
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d items sent, %0d results checked, %0d mismatches",
             items_sent, results_seen, fault_count);
    $display("tb: %0d victims, %0d evicts without victim, %0d unknown type reports",
             victims_seen, none_seen, type_errs_seen);
    if (fault_count == 0 && pending_outcomes.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
